[hdl/wpm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; the other design files, apart from wpm_ifs, refer to this package by scoped names.
package wpm_pkg;

	// Item function codes carried in the func field of an input beat
	typedef enum logic [1:0] {
		FUNC_CLEAR  = 2'd0,
		FUNC_APPEND = 2'd1,
		FUNC_TEXT   = 2'd2,
		FUNC_END    = 2'd3
	} func_t;

	// Wildcard symbols in the pattern
	localparam logic [7:0] SYM_STAR = 8'd42;
	localparam logic [7:0] SYM_ANY  = 8'd63;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic clear_pat;  // empty the pattern, clear overflow, rearm
		logic append;     // store one pattern symbol, rearm
		logic start;      // begin a sweep over the pattern
		logic text_mode;  // with start: the sweep consumes a text byte
		logic issue;      // read the next pattern position
		logic finish;     // close the sweep: commit or report
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic len_zero;    // pattern is empty
		logic last_issue;  // the read being issued is the last position
	} dp_stat_t;

endpackage

[hdl/wpm_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the wildcard pattern matcher.
// Depends on nothing; the input beat and the result beat have their own interface.
interface wpm_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] symbol;

	modport source (output valid, output func, output symbol, input ready);
	modport sink   (input valid, input func, input symbol, output ready);
endinterface

interface wpm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic overflow;

	modport source (output valid, output matched, output overflow, input ready);
	modport sink   (input valid, input matched, input overflow, output ready);
endinterface

[hdl/wildcard_pattern_matcher.sv]
`timescale 1ns / 1ps
// Top level of the wildcard pattern matcher: controller plus datapath.
// Depends on wpm_pkg, wpm_ifs, wpm_ctrl and wpm_datapath.
//
// Usage:
//   items   - input beats {func, symbol}: clear pattern, append a pattern
//             symbol ('*' any run, '?' any byte), text byte, end of string.
//   results - one beat {matched, overflow} per end-of-string item.
// Clear and append beats finish in the state that accepts them. A text byte
// or an end item walks the stored pattern one position per cycle through
// the pattern memory, then passes the drain and finish states; with an
// empty pattern it goes straight to finish. The result beat appears the cycle
// after an end item finishes and is held in an output register until taken.
// While a result waits, further beats are accepted only in the cycle that
// the receiver takes it; otherwise items.ready stays low.
// Reset empties the pattern, clears overflow and arms the first string; the
// pattern memory contents are not cleared, only its length.
// Appends past MAX_PATTERN symbols are dropped and flag overflow until the
// next clear; matched is then reported as 0.
module wildcard_pattern_matcher #(
	parameter int MAX_PATTERN = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	wpm_item_if.sink     items,
	wpm_result_if.source results
);

	wpm_pkg::dp_cmd_t  cmd;
	wpm_pkg::dp_stat_t stat;

	wpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_func   (items.func),
		.in_ready  (items.ready),
		.out_ready (results.ready),
		.out_valid (results.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	wpm_datapath #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.symbol   (items.symbol),
		.cmd      (cmd),
		.stat     (stat),
		.matched  (results.matched),
		.overflow (results.overflow)
	);

	// No beat is taken while the pattern sweep runs
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> !items.ready)
		else $error("input accepted during pattern sweep");

	// The sweep stops right after the last position is read
	a_sweep_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && stat.last_issue) |=> !cmd.issue)
		else $error("sweep ran past the pattern length");

	// At most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_pat, cmd.append, cmd.start, cmd.issue, cmd.finish}))
		else $error("conflicting datapath commands");

	// An overflowed pattern never reports a match
	a_overflow_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.overflow) |-> !results.matched)
		else $error("match reported with overflow");

endmodule

[hdl/wpm_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the wildcard pattern matcher: sequences each input beat
// into datapath commands and owns the result valid flag. Uses wpm_pkg.
module wpm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        in_func,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	input  wpm_pkg::dp_stat_t stat,
	output wpm_pkg::dp_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t         state_q;
	state_t         state_d;
	logic           end_q;
	logic           out_valid_q;
	logic           accept;
	wpm_pkg::func_t func;

	assign func      = wpm_pkg::func_t'(in_func);
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Decode commands and the next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						wpm_pkg::FUNC_CLEAR:  cmd.clear_pat = 1'b1;
						wpm_pkg::FUNC_APPEND: cmd.append = 1'b1;
						wpm_pkg::FUNC_TEXT: begin
							cmd.start     = 1'b1;
							cmd.text_mode = 1'b1;
							state_d       = stat.len_zero ? ST_FINISH : ST_SWEEP;
						end
						wpm_pkg::FUNC_END: begin
							cmd.start = 1'b1;
							state_d   = stat.len_zero ? ST_FINISH : ST_SWEEP;
						end
						default: cmd = '0;
					endcase
				end
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state, the item kind and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) begin
				end_q <= !cmd.text_mode;
			end
			if (cmd.finish && end_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[hdl/wpm_datapath.sv]
`timescale 1ns / 1ps
// Datapath for the wildcard pattern matcher: pattern memory, active position
// vectors and the one-position-per-cycle sweep. Uses wpm_pkg.
module wpm_datapath #(
	parameter int MAX_PATTERN = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        symbol,
	input  wpm_pkg::dp_cmd_t  cmd,
	output wpm_pkg::dp_stat_t stat,
	output logic              matched,
	output logic              overflow
);

	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int ACT_W  = MAX_PATTERN + 1;

	logic [7:0]       mem [MAX_PATTERN];
	logic [LEN_W-1:0] len_q;
	logic             too_long_q;
	logic [ACT_W-1:0] act_q;
	logic [ACT_W-1:0] nxt_q;
	logic             carry_q;
	logic             text_q;
	logic [7:0]       sym_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic             proc_s1;
	logic [LEN_W-1:0] pos_s1;
	logic [7:0]       rd_data_s1;
	logic             matched_q;
	logic             overflow_q;

	logic             len_full;
	logic             pos_act;
	logic             is_star;
	logic             is_hit;

	assign len_full      = (len_q == LEN_W'(MAX_PATTERN));
	assign stat.len_zero = (len_q == '0);
	assign stat.last_issue = (LEN_W'(rd_ptr_q) == len_q - LEN_W'(1));

	// Position under evaluation, with star closure from the position before
	assign pos_act = act_q[pos_s1] | carry_q;
	assign is_star = (rd_data_s1 == wpm_pkg::SYM_STAR);
	assign is_hit  = (rd_data_s1 == wpm_pkg::SYM_ANY) || (rd_data_s1 == sym_q);

	// Pattern memory: write on append, registered read during the sweep
	always_ff @(posedge clk) begin
		if (cmd.append && !len_full) begin
			mem[len_q[ADDR_W-1:0]] <= symbol;
		end
		rd_data_s1 <= mem[rd_ptr_q];
		pos_s1     <= LEN_W'(rd_ptr_q);
	end

	// Control state: length, overflow flag, active positions, read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			too_long_q <= 1'b0;
			act_q      <= ACT_W'(1);
			proc_s1    <= 1'b0;
		end else begin
			proc_s1 <= cmd.issue;
			if (cmd.clear_pat) begin
				len_q      <= '0;
				too_long_q <= 1'b0;
				act_q      <= ACT_W'(1);
			end else if (cmd.append) begin
				if (len_full) begin
					too_long_q <= 1'b1;
				end else begin
					len_q <= len_q + LEN_W'(1);
				end
				act_q <= ACT_W'(1);
			end else if (cmd.finish) begin
				act_q <= text_q ? nxt_q : ACT_W'(1);
			end
		end
	end

	// Sweep registers: read pointer, closure carry, the next active vector, item kind and text byte
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rd_ptr_q <= '0;
			carry_q  <= 1'b0;
			nxt_q    <= '0;
			text_q   <= cmd.text_mode;
			sym_q    <= symbol;
		end else begin
			if (cmd.issue) begin
				rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
			end
			if (proc_s1) begin
				carry_q <= pos_act & is_star;
				if (text_q && pos_act && is_star) begin
					nxt_q[pos_s1] <= 1'b1;
				end
				if (text_q && pos_act && !is_star && is_hit) begin
					nxt_q[pos_s1 + LEN_W'(1)] <= 1'b1;
				end
			end
		end
	end

	// Result register: loaded when an end item finishes
	always_ff @(posedge clk) begin
		if (cmd.finish && !text_q) begin
			matched_q  <= !too_long_q && (act_q[len_q] | carry_q);
			overflow_q <= too_long_q;
		end
	end

	assign matched  = matched_q;
	assign overflow = overflow_q;

endmodule
